@@ sv/segmented_bitmap_allocator_core_defines.svh @@
`ifndef SEGMENTED_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define SEGMENTED_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// Concurrent check that is switched off while reset is high.
`define SBA_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that holds on every clock edge, reset included.
`define SBA_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sba_pkg.sv @@
`default_nettype none

package sba_pkg;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // Width of the slice of a segment bitmap that the search unit examines per cycle.
   localparam int CHUNK_W  = 64;
   localparam int CHUNK_AW = 6;

   typedef struct packed {
      logic       command;
      logic [3:0] segment;
      logic [7:0] index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] out_segment;
      logic [7:0] out_index;
   } rsp_type;

   typedef struct packed {
      logic                found;
      logic [CHUNK_AW-1:0] pos;
   } ffz_res_type;

endpackage

`default_nettype wire

@@ sv/sba_chan_if.sv @@
`default_nettype none

interface sba_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/segmented_bitmap_allocator_core.sv @@
// Segmented first-fit bitmap allocator.
// req_if carries one request: an allocate (command 0) or a free of the entry named by
// segment and index (command 1). rsp_if returns exactly one result per request:
// status, and for a successful allocate the segment and index that were taken.
// The bitmaps live in one RAM row per segment. A free reads the row, clears the bit
// and writes it back. An allocate reads segments from 0 upward and searches each row
// one 64-bit slice per cycle in a shared find-first-zero unit, and it stops in the
// first segment with room.
// The block takes one request at a time; req_if.ready is high only while it is idle.
// A finished result sits in an output register; if rsp_if.ready is low, the next
// result waits until that register is taken, and nothing is lost.
// Reset clears every bitmap at once through one valid flag per segment row; no
// clearing pass is needed, and a request is accepted in the cycle after reset.
`default_nettype none
`include "segmented_bitmap_allocator_core_defines.svh"

module segmented_bitmap_allocator_core import sba_pkg::*; #(
   parameter int SEGMENTS            = 16,
   parameter int ENTRIES_PER_SEGMENT = 255
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sba_chan_if.sink    req_if,
   sba_chan_if.source  rsp_if
);

   localparam int SW     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int NCHUNK = (ENTRIES_PER_SEGMENT + CHUNK_W - 1) / CHUNK_W;
   localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int RW     = NCHUNK * CHUNK_W;
   localparam int IW     = $clog2(RW);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_CLEAR = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [SEGMENTS-1:0]      valid_ff, valid_in;
   logic                     rd_valid_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic                     cmd_ff, cmd_in;
   logic [SW-1:0]            seg_ff, seg_in;
   logic [7:0]               idx_ff, idx_in;
   logic [CIW-1:0]           chunk_ff, chunk_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [1:0]               st_ff, st_in;
   logic [3:0]               oseg_ff, oseg_in;
   logic [7:0]               oidx_ff, oidx_in;

   logic                     ram_re, ram_we;
   logic [SW-1:0]            ram_raddr;
   logic [ENTRIES_PER_SEGMENT-1:0] ram_rdata, ram_wdata;
   logic [CHUNK_W-1:0]       chunk_bits;
   ffz_res_type              ffz_res;
   logic [IW-1:0]            alloc_idx;
   logic [IW+7:0]            idx_ext;
   logic [SW+3:0]            seg_ext;
   logic [RW-1:0]            row_set, row_clr;
   logic                     req_fire, range_bad;

   sba_ram #(
      .WIDTH (ENTRIES_PER_SEGMENT),
      .DEPTH (SEGMENTS),
      .AW    (SW)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (seg_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign chunk_bits = row_ff[chunk_ff * CHUNK_W +: CHUNK_W];

   sba_ffz u_ffz (
      .chunk (chunk_bits),
      .res   (ffz_res)
   );

   assign alloc_idx = (IW'(chunk_ff) << CHUNK_AW) | IW'(ffz_res.pos);
   assign idx_ext   = (IW + 8)'(alloc_idx);
   assign seg_ext   = (SW + 4)'(seg_ff);
   assign row_set   = row_ff | (RW'(1) << alloc_idx);
   assign row_clr   = row_ff & ~(RW'(1) << idx_ff);

   assign req_fire  = req_if.valid && req_if.ready;
   assign range_bad = (32'(req_if.payload.segment) >= 32'(SEGMENTS)) ||
                      (32'(req_if.payload.index) >= 32'(ENTRIES_PER_SEGMENT));

   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cmd_in       = cmd_ff;
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      chunk_in     = chunk_ff;
      row_in       = row_ff;
      st_in        = st_ff;
      oseg_in      = oseg_ff;
      oidx_in      = oidx_ff;
      ram_re       = 1'b0;
      ram_raddr    = seg_ff;
      ram_we       = 1'b0;
      ram_wdata    = row_ff[ENTRIES_PER_SEGMENT-1:0];

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_if.payload.command;
               idx_in  = req_if.payload.index;
               st_in   = ST_OK;
               oseg_in = '0;
               oidx_in = '0;
               if (req_if.payload.command == CMD_ALLOC) begin
                  seg_in    = '0;
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  state_in  = S_READ;
               end else if (range_bad) begin
                  st_in    = ST_RANGE;
                  state_in = S_DONE;
               end else begin
                  seg_in    = SW'(req_if.payload.segment);
                  ram_re    = 1'b1;
                  ram_raddr = SW'(req_if.payload.segment);
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            // Rows never written since reset read as all free; slice padding reads as used.
            row_in = '1;
            row_in[ENTRIES_PER_SEGMENT-1:0] = rd_valid_ff ? ram_rdata : '0;
            chunk_in = '0;
            state_in = (cmd_ff == CMD_ALLOC) ? S_SCAN : S_CLEAR;
         end
         S_SCAN: begin
            if (ffz_res.found) begin
               ram_we           = 1'b1;
               ram_wdata        = row_set[ENTRIES_PER_SEGMENT-1:0];
               valid_in[seg_ff] = 1'b1;
               oseg_in          = seg_ext[3:0];
               oidx_in          = idx_ext[7:0];
               state_in         = S_DONE;
            end else if (chunk_ff != CIW'(NCHUNK - 1)) begin
               chunk_in = chunk_ff + 1'b1;
            end else if (seg_ff == SW'(SEGMENTS - 1)) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else begin
               seg_in    = seg_ff + 1'b1;
               ram_re    = 1'b1;
               ram_raddr = seg_ff + 1'b1;
               state_in  = S_READ;
            end
         end
         S_CLEAR: begin
            ram_we           = 1'b1;
            ram_wdata        = row_clr[ENTRIES_PER_SEGMENT-1:0];
            valid_in[seg_ff] = 1'b1;
            state_in         = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = st_ff;
               rsp_data_in.out_segment = oseg_ff;
               rsp_data_in.out_index   = oidx_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chunk_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chunk_ff     <= chunk_in;
         if (ram_re) begin
            rd_valid_ff <= valid_ff[ram_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cmd_ff      <= cmd_in;
      seg_ff      <= seg_in;
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      st_ff       <= st_in;
      oseg_ff     <= oseg_in;
      oidx_ff     <= oidx_in;
   end

   `SBA_ASSERT_RST(a_busy_after_accept, clock, reset, req_fire |=> !req_if.ready, "ready high right after a request was accepted")
   `SBA_ASSERT_RST(a_write_phase, clock, reset, ram_we |-> (state_ff == S_SCAN || state_ff == S_CLEAR), "bitmap written outside a scan or clear step")
   `SBA_ASSERT_RST(a_error_zero, clock, reset, (rsp_valid_ff && rsp_data_ff.status != ST_OK) |-> (rsp_data_ff.out_segment == 4'd0 && rsp_data_ff.out_index == 8'd0), "failed request returned a nonzero location")
   `SBA_ASSERT(a_chunk_range, clock, reset || (chunk_ff <= CIW'(NCHUNK - 1)), "slice pointer beyond the end of the row")

endmodule

`default_nettype wire

@@ sv/sba_ram.sv @@
`default_nettype none

module sba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/sba_ffz.sv @@
`default_nettype none

module sba_ffz import sba_pkg::*; (
   input  wire logic [CHUNK_W-1:0] chunk,
   output ffz_res_type             res
);

   // Lowest clear bit wins, so walk from the top down and let lower hits overwrite.
   always_comb begin
      res.found = ~&chunk;
      res.pos   = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         if (!chunk[i]) begin
            res.pos = CHUNK_AW'(i);
         end
      end
   end

endmodule

`default_nettype wire
